// ===== hw/rtl/dfcd_pkg.sv =====
package dfcd_pkg;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_DEV   = 3'd3,
    ST_BAD_CSUM  = 3'd4,
    ST_BAD_END   = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Configuration register indexes
  localparam logic [7:0] REG_START_CODE = 8'd0;
  localparam logic [7:0] REG_END_CODE   = 8'd1;

  localparam logic [7:0] START_CODE_RST = 8'd16;
  localparam logic [7:0] END_CODE_RST   = 8'd22;

  localparam logic [7:0] DEV_BROADCAST = 8'd255;
  localparam logic [7:0] DEV_MAX       = 8'd99;
  localparam logic [1:0] HOLD_DEPTH    = 2'd2;
  localparam logic [8:0] POS_MAX       = 9'd511;
  localparam logic [8:0] MIN_FRAME     = 9'd5;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    status;
    logic [7:0] device;
    logic [7:0] request;
    logic [7:0] count;
    logic       last;
  } res_t;

  // Up to two results produced by one byte, packed from slot 0
  typedef struct packed {
    logic [1:0]      num;
    res_t [1:0]      res;
  } push_t;

endpackage

// ===== hw/rtl/delimited_frame_checksum_decoder.sv =====
// Channel   Dir  Signals                         Payload
// s_axis    in   s_tvalid s_tready s_tdata s_tlast  rx_byte, end_of_buffer
// m_axis    out  m_tvalid m_tready m_tdata m_tuser  result fields, last_of_run
//                m_tlast
// cfg       in   cfg_valid cfg_ready cfg_index      start_code / end_code writes
//                cfg_data
//
// One byte per cycle: a byte sits in the input register, is decoded
// combinationally and its results (zero, one or two) are written to a 4-entry
// result queue. A byte that ends a frame after a confirmed data byte yields two
// results, which drain one per cycle while m_tready is high. rst is synchronous
// and clears the frame state and queue; config regs return to 16 / 22. The input
// stalls only when the queue lacks room for two results.
module delimited_frame_checksum_decoder #(
  parameter int MAX_DATA = 255
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // end_of_buffer
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data_byte, [10:8] frame_status,
                                 // [18:11] device_number, [26:19] request_code,
                                 // [34:27] data_count, [39:35] zero
  output logic        m_tuser,   // result_kind
  output logic        m_tlast,   // last_of_run
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       room;
  logic       fire;
  logic [7:0] start_code;
  logic [7:0] end_code;

  dfcd_pkg::push_t push;
  dfcd_pkg::res_t  out_res;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= dfcd_pkg::START_CODE_RST;
      end_code   <= dfcd_pkg::END_CODE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == dfcd_pkg::REG_START_CODE) begin
        start_code <= cfg_data;
      end else if (cfg_index == dfcd_pkg::REG_END_CODE) begin
        end_code <= cfg_data;
      end
    end
  end

  // Input register: refilled in the same cycle it is consumed
  assign fire     = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  dfcd_core #(
    .MAX_DATA(MAX_DATA)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .rx_byte      (in_byte),
    .end_of_buffer(in_last),
    .start_code   (start_code),
    .end_code     (end_code),
    .push         (push)
  );

  dfcd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;
  assign m_tdata = {5'b00000, out_res.count, out_res.request, out_res.device,
                    out_res.status, out_res.data_byte};

endmodule

// ===== hw/rtl/dfcd_core.sv =====
module dfcd_core #(
  parameter int MAX_DATA = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic                end_of_buffer,
  input  logic [7:0]          start_code,
  input  logic [7:0]          end_code,
  output dfcd_pkg::push_t     push
);

  localparam logic [7:0] MAX_CNT = 8'(MAX_DATA);

  logic [8:0]        pos, pos_next;
  logic [7:0]        h0, h0_next;
  logic [7:0]        h1, h1_next;
  logic [1:0]        hc, hc_next;
  logic [7:0]        sum, sum_next;
  dfcd_pkg::status_t err, err_next;
  logic [7:0]        dev, dev_next;
  logic [7:0]        req, req_next;
  logic [7:0]        cnt, cnt_next;

  always_comb begin
    pos_next = pos;
    h0_next  = h0;
    h1_next  = h1;
    hc_next  = hc;
    sum_next = sum;
    err_next = err;
    dev_next = dev;
    req_next = req;
    cnt_next = cnt;
    push     = '0;

    if (pos == 9'd0) begin
      if (rx_byte != start_code && err_next == dfcd_pkg::ST_OK) begin
        err_next = dfcd_pkg::ST_BAD_START;
      end
    end else if (pos == 9'd1) begin
      dev_next = rx_byte;
      sum_next = rx_byte;
      if (rx_byte != dfcd_pkg::DEV_BROADCAST && rx_byte > dfcd_pkg::DEV_MAX &&
          err_next == dfcd_pkg::ST_OK) begin
        err_next = dfcd_pkg::ST_BAD_DEV;
      end
    end else if (pos == 9'd2) begin
      req_next = rx_byte;
      sum_next = sum + rx_byte;
    end else if (hc >= dfcd_pkg::HOLD_DEPTH) begin
      // oldest held byte is now confirmed as data
      if (cnt < MAX_CNT) begin
        sum_next = sum + h0;
        cnt_next = cnt + 8'd1;
        push.res[0].kind      = dfcd_pkg::KIND_DATA;
        push.res[0].data_byte = h0;
        push.res[0].last      = ~end_of_buffer;
        push.num              = 2'd1;
      end else if (err_next == dfcd_pkg::ST_OK) begin
        err_next = dfcd_pkg::ST_TOO_LONG;
      end
      h0_next = h1;
      h1_next = rx_byte;
    end else begin
      if (hc[0]) begin
        h1_next = rx_byte;
      end else begin
        h0_next = rx_byte;
      end
      hc_next = hc + 2'd1;
    end

    if (pos < dfcd_pkg::POS_MAX) begin
      pos_next = pos + 9'd1;
    end

    if (end_of_buffer) begin
      if (pos_next < dfcd_pkg::MIN_FRAME) begin
        if (err_next == dfcd_pkg::ST_OK) begin
          err_next = dfcd_pkg::ST_SHORT;
        end
      end else if (err_next == dfcd_pkg::ST_OK || err_next == dfcd_pkg::ST_TOO_LONG) begin
        if (h0_next != ~sum_next) begin
          err_next = dfcd_pkg::ST_BAD_CSUM;
        end else if (h1_next != end_code) begin
          err_next = dfcd_pkg::ST_BAD_END;
        end
      end
      if (push.num == 2'd0) begin
        push.res[0].kind    = dfcd_pkg::KIND_STATUS;
        push.res[0].status  = err_next;
        push.res[0].device  = dev_next;
        push.res[0].request = req_next;
        push.res[0].count   = cnt_next;
        push.res[0].last    = 1'b1;
      end else begin
        push.res[1].kind    = dfcd_pkg::KIND_STATUS;
        push.res[1].status  = err_next;
        push.res[1].device  = dev_next;
        push.res[1].request = req_next;
        push.res[1].count   = cnt_next;
        push.res[1].last    = 1'b1;
      end
      push.num = push.num + 2'd1;
      // frame done: back to the idle frame state
      pos_next = '0;
      h0_next  = '0;
      h1_next  = '0;
      hc_next  = '0;
      sum_next = '0;
      err_next = dfcd_pkg::ST_OK;
      dev_next = '0;
      req_next = '0;
      cnt_next = '0;
    end

    if (!fire) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      h0  <= '0;
      h1  <= '0;
      hc  <= '0;
      sum <= '0;
      err <= dfcd_pkg::ST_OK;
      dev <= '0;
      req <= '0;
      cnt <= '0;
    end else if (fire) begin
      pos <= pos_next;
      h0  <= h0_next;
      h1  <= h1_next;
      hc  <= hc_next;
      sum <= sum_next;
      err <= err_next;
      dev <= dev_next;
      req <= req_next;
      cnt <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/dfcd_outq.sv =====
module dfcd_outq (
  input  logic             clk,
  input  logic             rst,
  input  dfcd_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output dfcd_pkg::res_t   out_res
);

  dfcd_pkg::res_t entries [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_res   = entries[rptr];
  // room for a full pair regardless of this cycle's pop
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wptr] <= push.res[0];
    end
    if (push.num == 2'd2) begin
      entries[wptr + 2'd1] <= push.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.num;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, push.num} - {2'b00, pop};
    end
  end

endmodule
